>>> rtl/lpht_pkg.sv
// Package: shared types and constants for the linear probe hash table unit.
package lpht_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned ValW  = 64;
  localparam int unsigned CntW  = 9;
  localparam int unsigned HashW = 32;

  localparam logic [HashW-1:0] HashBasis = 32'h811c9dc5;
  localparam logic [HashW-1:0] HashPrime = 32'h01000193;

  localparam logic [1:0] CmdSet    = 2'd0;
  localparam logic [1:0] CmdGet    = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;
  localparam logic [1:0] CmdExists = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  localparam logic [1:0] MarkEmpty = 2'd0;
  localparam logic [1:0] MarkLive  = 2'd1;
  localparam logic [1:0] MarkTomb  = 2'd2;

  localparam logic [3:0] RegSlotsInUse = 4'd0;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input transaction, start hashing
    logic hash_step;  // fold one key byte
    logic mod_start;  // start home slot reduction
    logic mod_step;   // one restoring step
    logic probe_init; // set probe index to home slot
    logic rd_issue;   // read slot at probe index
    logic advance;    // examine read slot and move on
    logic commit;     // apply write and form result
  } lpht_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic init_done;  // slot marks cleared after reset
    logic hash_done;
    logic mod_done;
    logic probe_done;
  } lpht_stat_t;

endpackage

>>> rtl/lpht_stream_if.sv
// Interfaces: command and result channels with valid/ready handshake.
interface lpht_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key;
  logic [63:0] new_value;
  modport source (output valid, command, key, new_value, input ready);
  modport sink (input valid, command, key, new_value, output ready);
endinterface

interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic        found;
  logic [1:0]  status;
  logic [8:0]  entries;
  modport source (output valid, read_value, found, status, entries, input ready);
  modport sink (input valid, read_value, found, status, entries, output ready);
endinterface

>>> rtl/lpht_datapath.sv
// Datapath: key trim and hash, home slot reduction, probe walk and slot memories.
module lpht_datapath #(
  parameter int unsigned TableDepth = 256,
  parameter int unsigned KeyBytes   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpht_pkg::lpht_cmd_t         cmd_i,
  output lpht_pkg::lpht_stat_t        stat_o,
  input  logic [1:0]                  command_i,
  input  logic [lpht_pkg::KeyW-1:0]   key_i,
  input  logic [lpht_pkg::ValW-1:0]   new_value_i,
  input  logic [lpht_pkg::CntW-1:0]   slots_i,
  output logic [lpht_pkg::ValW-1:0]   read_value_o,
  output logic                        found_o,
  output logic [1:0]                  status_o,
  output logic [lpht_pkg::CntW-1:0]   entries_o
);
  localparam int unsigned IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NW    = $clog2(TableDepth + 1);
  localparam int unsigned ByteW = $clog2(KeyBytes + 1);
  localparam int unsigned HW    = lpht_pkg::HashW;
  localparam int unsigned ModW  = $clog2(HW + 1);

  // Slot stores
  logic [1:0]                 mark_mem [TableDepth];
  logic [lpht_pkg::KeyW-1:0]  skey_mem [TableDepth];
  logic [lpht_pkg::ValW-1:0]  sval_mem [TableDepth];

  logic [1:0]                 cmd_q;
  logic [lpht_pkg::KeyW-1:0]  key_q;
  logic [lpht_pkg::ValW-1:0]  nval_q;
  logic [HW-1:0]              hash_q;
  logic [ByteW-1:0]           byte_q;
  logic                       hdone_q;
  logic [NW-1:0]              n_q;
  logic [HW-1:0]              rem_q;
  logic [HW-1:0]              quo_q;
  logic [ModW-1:0]            mcnt_q;
  logic [IdxW-1:0]            idx_q;
  logic [NW-1:0]              steps_q;
  logic                       pdone_q;
  logic [1:0]                 rmark_q;
  logic [lpht_pkg::KeyW-1:0]  rkey_q;
  logic [lpht_pkg::ValW-1:0]  rval_q;
  logic                       at_v_q, free_v_q;
  logic [IdxW-1:0]            at_q, free_q;
  logic [lpht_pkg::CntW-1:0]  live_q;
  logic [lpht_pkg::ValW-1:0]  rv_q;
  logic                       found_q;
  logic [1:0]                 status_q;
  logic                       clr_busy_q;
  logic [IdxW-1:0]            clr_idx_q;
  logic                       mark_we;
  logic [IdxW-1:0]            mark_widx;
  logic [1:0]                 mark_wdata;

  // Effective slot count, clamped to 1..TableDepth
  logic [NW-1:0] n_eff;
  always_comb begin
    if (slots_i == '0) n_eff = NW'(1);
    else if ({{32{1'b0}}, slots_i} > 41'(TableDepth)) n_eff = NW'(TableDepth);
    else n_eff = NW'(slots_i);
  end

  // Current hash byte
  logic [7:0]    cur_byte;
  logic [HW-1:0] hash_mul;
  assign cur_byte = key_q[8*byte_q[ByteW-1:0] +: 8];
  assign hash_mul = hash_q * lpht_pkg::HashPrime;

  // Restoring reduction step
  logic [HW:0] trial;
  assign trial = {rem_q, quo_q[HW-1]} - {{(HW+1-NW){1'b0}}, n_q};

  logic [IdxW-1:0] idx_next;
  assign idx_next = ({{(NW-IdxW){1'b0}}, idx_q} + NW'(1) == n_q) ? '0 : idx_q + IdxW'(1);

  assign stat_o.init_done  = !clr_busy_q;
  assign stat_o.hash_done  = hdone_q;
  assign stat_o.mod_done   = (mcnt_q == '0);
  assign stat_o.probe_done = pdone_q;

  logic key_eq;
  assign key_eq = (rkey_q == key_q);

  // Sweep every slot mark to empty after reset, one slot per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + IdxW'(1);
      if (clr_idx_q == IdxW'(TableDepth - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Select the single mark write: sweep, new entry or tombstone
  always_comb begin
    mark_we    = 1'b0;
    mark_widx  = clr_idx_q;
    mark_wdata = lpht_pkg::MarkEmpty;
    if (clr_busy_q) begin
      mark_we = 1'b1;
    end else if (cmd_i.commit) begin
      if (cmd_q == lpht_pkg::CmdSet && !at_v_q && free_v_q) begin
        mark_we    = 1'b1;
        mark_widx  = free_q;
        mark_wdata = lpht_pkg::MarkLive;
      end else if (cmd_q == lpht_pkg::CmdRemove && at_v_q) begin
        mark_we    = 1'b1;
        mark_widx  = at_q;
        mark_wdata = lpht_pkg::MarkTomb;
      end
    end
  end

  // Mark memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_widx] <= mark_wdata;
    if (cmd_i.rd_issue) rmark_q <= mark_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      hdone_q <= 1'b0;
      mcnt_q  <= '0;
      pdone_q <= 1'b0;
      found_q <= 1'b0;
      status_q <= lpht_pkg::StatOk;
    end else begin
      // Capture transaction
      if (cmd_i.load) begin
        cmd_q   <= command_i;
        nval_q  <= new_value_i;
        key_q   <= key_i;
        hash_q  <= lpht_pkg::HashBasis;
        byte_q  <= '0;
        hdone_q <= 1'b0;
        n_q     <= n_eff;
      end
      // Fold one byte; trim key at terminator
      if (cmd_i.hash_step && !hdone_q) begin
        if (byte_q == ByteW'(KeyBytes) || cur_byte == 8'd0) begin
          hdone_q <= 1'b1;
          for (int b = 0; b < 8; b++) begin
            if (b >= int'(byte_q)) key_q[8*b +: 8] <= 8'd0;
          end
        end else begin
          hash_q <= hash_mul ^ {{24{cur_byte[7]}}, cur_byte};
          byte_q <= byte_q + ByteW'(1);
        end
      end
      // Home slot reduction
      if (cmd_i.mod_start) begin
        rem_q  <= '0;
        quo_q  <= hash_q;
        mcnt_q <= ModW'(HW);
      end else if (cmd_i.mod_step && mcnt_q != '0) begin
        quo_q  <= {quo_q[HW-2:0], 1'b0};
        rem_q  <= trial[HW] ? {rem_q[HW-2:0], quo_q[HW-1]} : trial[HW-1:0];
        mcnt_q <= mcnt_q - ModW'(1);
      end
      // Probe walk
      if (cmd_i.probe_init) begin
        idx_q    <= rem_q[IdxW-1:0];
        steps_q  <= '0;
        pdone_q  <= 1'b0;
        at_v_q   <= 1'b0;
        free_v_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        if (rmark_q == lpht_pkg::MarkLive) begin
          if (key_eq) begin
            at_v_q  <= 1'b1;
            at_q    <= idx_q;
            pdone_q <= 1'b1;
          end
        end else begin
          if (cmd_q == lpht_pkg::CmdSet && !free_v_q) begin
            free_v_q <= 1'b1;
            free_q   <= idx_q;
          end
          if (rmark_q == lpht_pkg::MarkEmpty) pdone_q <= 1'b1;
        end
        idx_q   <= idx_next;
        steps_q <= steps_q + NW'(1);
        if (steps_q + NW'(1) == n_q) pdone_q <= 1'b1;
      end
      // Apply and form result
      if (cmd_i.commit) begin
        rv_q     <= '0;
        found_q  <= at_v_q;
        status_q <= lpht_pkg::StatOk;
        if (cmd_q == lpht_pkg::CmdSet) begin
          if (!at_v_q) begin
            if (free_v_q) begin
              live_q <= live_q + lpht_pkg::CntW'(1);
            end else begin
              status_q <= lpht_pkg::StatFull;
            end
          end
        end else if (!at_v_q) begin
          status_q <= lpht_pkg::StatNotFound;
        end else if (cmd_q == lpht_pkg::CmdGet) begin
          rv_q <= rval_q;
        end else if (cmd_q == lpht_pkg::CmdRemove) begin
          if (live_q != '0) live_q <= live_q - lpht_pkg::CntW'(1);
        end
      end
    end
  end

  // Key and value memories: one read port, one write port
  logic [IdxW-1:0] wr_idx;
  assign wr_idx = at_v_q ? at_q : free_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rkey_q <= skey_mem[idx_q];
      rval_q <= sval_mem[idx_q];
    end else if (cmd_i.advance && rmark_q == lpht_pkg::MarkLive && key_eq) begin
      rval_q <= sval_mem[idx_q];
    end
    if (cmd_i.commit && cmd_q == lpht_pkg::CmdSet && (at_v_q || free_v_q)) begin
      skey_mem[wr_idx] <= key_q;
      sval_mem[wr_idx] <= nval_q;
    end
  end

  assign read_value_o = rv_q;
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign entries_o    = live_q;
endmodule

>>> rtl/lpht_ctrl.sv
// Controller: sequences hash, reduction, probe walk and result handoff.
module lpht_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  lpht_pkg::lpht_stat_t  stat_i,
  output lpht_pkg::lpht_cmd_t   cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StHash, StMod, StRead, StExam, StCommit, StOut
  } state_e;

  state_e state_q;
  logic   ov_q;

  assign in_ready_o  = (state_q == StIdle) && !ov_q && stat_i.init_done;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = in_valid_i && in_ready_o;
    cmd_o.hash_step  = (state_q == StHash);
    cmd_o.mod_start  = (state_q == StHash) && stat_i.hash_done;
    cmd_o.mod_step   = (state_q == StMod);
    cmd_o.probe_init = (state_q == StMod) && stat_i.mod_done;
    cmd_o.rd_issue   = (state_q == StRead);
    cmd_o.advance    = (state_q == StExam);
    cmd_o.commit     = (state_q == StCommit) && stat_i.probe_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        StIdle:   if (in_valid_i && in_ready_o) state_q <= StHash;
        StHash:   if (stat_i.hash_done) state_q <= StMod;
        StMod:    if (stat_i.mod_done) state_q <= StRead;
        StRead:   state_q <= StExam;
        StExam:   state_q <= StCommit;
        // Continue the walk unless finished
        StCommit: state_q <= stat_i.probe_done ? StOut : StRead;
        StOut: begin
          ov_q    <= 1'b1;
          state_q <= StIdle;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule

>>> rtl/linear_probe_hash_table_unit.sv
// Sequence: accept, hash one key byte per step up to the terminator, bit-serial reduction to the home
// slot, then read, examine and commit states per probed slot and an output state before the result is valid.
// Throughput: one command at a time; the probe walk and the bit-serial reduction set the pace.
// A result register holds the answer until taken; the next command is taken after it.
// Reset (rst_ni, async active low): live count zero, slots_in_use 256, then a sweep over all TABLE_DEPTH
// slots marks them empty before the first command; key and value memories are not cleared.
module linear_probe_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpht_cmd_if.sink    cmd_in,
  lpht_rsp_if.source  rsp_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  lpht_pkg::lpht_cmd_t  cmd;
  lpht_pkg::lpht_stat_t stat;
  logic [lpht_pkg::CntW-1:0] slots_q;

  // Configuration register at address 0; writes to other addresses are ignored
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) slots_q <= lpht_pkg::CntW'(256);
    else if (psel && penable && pwrite && paddr == 1'b0) slots_q <= pwdata[8:0];
  end
  assign prdata = {23'd0, slots_q};

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(cmd_in.valid), .in_ready_o(cmd_in.ready),
    .out_valid_o(rsp_out.valid), .out_ready_i(rsp_out.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  lpht_datapath #(.TableDepth(TABLE_DEPTH), .KeyBytes(KEY_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .command_i(cmd_in.command), .key_i(cmd_in.key), .new_value_i(cmd_in.new_value),
    .slots_i(slots_q),
    .read_value_o(rsp_out.read_value), .found_o(rsp_out.found),
    .status_o(rsp_out.status), .entries_o(rsp_out.entries)
  );
endmodule

>>> verif/tb_linear_probe_hash_table_unit.sv
// Testbench for the linear probe hash table unit: random and directed commands checked against a predictor.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit;

  localparam int unsigned Depth     = 256;
  localparam int unsigned WatchLim  = 20000;
  localparam int unsigned HoldLen   = 600;
  localparam int unsigned PoolSize  = 48;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [63:0] new_value;
  } table_cmd_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        found;
    logic [1:0]  status;
    logic [8:0]  entries;
  } table_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driven copies of every block input, known from time zero
  logic        cmd_valid   = 1'b0;
  table_cmd_t  cmd_payload = '0;
  logic        rsp_ready   = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [0:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  lpht_cmd_if cmd_if ();
  lpht_rsp_if rsp_if ();

  assign cmd_if.valid     = cmd_valid;
  assign cmd_if.command   = cmd_payload.command;
  assign cmd_if.key       = cmd_payload.key;
  assign cmd_if.new_value = cmd_payload.new_value;
  assign rsp_if.ready     = rsp_ready;

  linear_probe_hash_table_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_in  (cmd_if.sink),
    .rsp_out (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  logic [1:0]  shadow_mark [Depth];
  logic [63:0] shadow_key  [Depth];
  logic [63:0] shadow_value[Depth];
  logic [8:0]  shadow_live;
  logic [8:0]  shadow_slots;

  table_cmd_t  pending_cmds[$];
  table_rsp_t  expected_rsps[$];
  logic [63:0] key_pool[PoolSize];

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_answered = 0;
  int unsigned n_hits     = 0;
  int unsigned n_misses   = 0;
  int unsigned n_full     = 0;
  int unsigned n_cfg      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Trim a raw key at its first zero byte and fold its bytes into the hash
  function automatic logic [63:0] trim_and_hash(input logic [63:0] raw, output logic [31:0] h);
    logic [63:0] k;
    logic [7:0]  b;
    bit          stop;
    k = '0;
    h = lpht_pkg::HashBasis;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'd0) stop = 1'b1;
      if (!stop) begin
        k[8*i +: 8] = b;
        h = h * lpht_pkg::HashPrime;
        h = h ^ {{24{b[7]}}, b};
      end
    end
    return k;
  endfunction

  // Apply one command to the shadow table and return the answer it gives
  function automatic table_rsp_t apply_table_cmd(input table_cmd_t c);
    table_rsp_t  r;
    logic [31:0] h;
    logic [63:0] k;
    int unsigned n, idx, home;
    int          hit, free_slot;
    bit          stop;
    r = '0;
    k = trim_and_hash(c.key, h);
    n = (shadow_slots == 0) ? 1 : ((shadow_slots > Depth) ? Depth : shadow_slots);
    home = h % n;
    idx = home;
    hit = -1;
    free_slot = -1;
    stop = 1'b0;
    for (int s = 0; s < n; s++) begin
      if (!stop) begin
        if (shadow_mark[idx] == lpht_pkg::MarkLive) begin
          if (shadow_key[idx] == k) begin
            hit = idx;
            stop = 1'b1;
          end
        end else begin
          if (free_slot < 0 && shadow_mark[idx] == lpht_pkg::MarkEmpty) free_slot = idx;
          if (free_slot < 0 && shadow_mark[idx] == lpht_pkg::MarkTomb &&
              c.command == lpht_pkg::CmdSet)
            free_slot = idx;
          if (shadow_mark[idx] == lpht_pkg::MarkEmpty) stop = 1'b1;
        end
        idx = (idx + 1 == n) ? 0 : idx + 1;
      end
    end
    if (c.command == lpht_pkg::CmdSet) begin
      if (hit >= 0) begin
        shadow_value[hit] = c.new_value;
        r.found = 1'b1;
      end else if (free_slot >= 0) begin
        shadow_mark[free_slot]  = lpht_pkg::MarkLive;
        shadow_key[free_slot]   = k;
        shadow_value[free_slot] = c.new_value;
        shadow_live = shadow_live + 1;
      end else begin
        r.status = lpht_pkg::StatFull;
      end
    end else if (hit < 0) begin
      r.status = lpht_pkg::StatNotFound;
    end else begin
      r.found = 1'b1;
      if (c.command == lpht_pkg::CmdGet) r.read_value = shadow_value[hit];
      if (c.command == lpht_pkg::CmdRemove) begin
        shadow_mark[hit] = lpht_pkg::MarkTomb;
        if (shadow_live > 0) shadow_live = shadow_live - 1;
      end
    end
    r.entries = shadow_live;
    return r;
  endfunction

  // Build a key of the given length with random nonzero bytes and junk past the end
  function automatic logic [63:0] make_key(input int unsigned len);
    logic [63:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      if (i < len) begin
        if (k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'd1;
      end else if (i == len) begin
        k[8*i +: 8] = 8'd0;
      end
    end
    return k;
  endfunction

  // Re-randomize the bytes after the terminator of a pooled key
  function automatic logic [63:0] reuse_key(input logic [63:0] base);
    logic [63:0] junk;
    logic [63:0] k;
    bit          past;
    junk = {$urandom, $urandom};
    k = base;
    past = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (past) k[8*i +: 8] = junk[8*i +: 8];
      if (base[8*i +: 8] == 8'd0) past = 1'b1;
    end
    return k;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [63:0] k, input logic [63:0] v);
    table_cmd_t c;
    c.command   = op;
    c.key       = k;
    c.new_value = v;
    pending_cmds.push_back(c);
  endtask

  // Queue well-formed traffic over a fresh key pool, with some noise keys
  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    logic [1:0]  op;
    logic [63:0] k;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = make_key($urandom_range(0, 8));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = lpht_pkg::CmdSet;
      else if (pick < 65) op = lpht_pkg::CmdGet;
      else if (pick < 85) op = lpht_pkg::CmdRemove;
      else op = lpht_pkg::CmdExists;
      if ($urandom_range(0, 9) == 0) k = make_key($urandom_range(0, 8));
      else k = reuse_key(key_pool[$urandom_range(0, PoolSize - 1)]);
      queue_cmd(op, k, {$urandom, $urandom});
    end
  endtask

  // Let the queued traffic drain completely before touching the register
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_slots(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= lpht_pkg::RegSlotsInUse[0:0];
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_slots = value[8:0];
    n_cfg++;
  endtask

  // Driver: hold the offer until taken, then idle at random or offer the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_if.ready) begin
        expected_rsps.push_back(apply_table_cmd(cmd_payload));
        void'(pending_cmds.pop_front());
        n_accepted++;
      end
      if (!cmd_valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 &&
            ((n_accepted >= 300 && n_accepted < 420) || $urandom_range(0, 99) >= 32)) begin
          cmd_valid   <= 1'b1;
          cmd_payload <= pending_cmds[0];
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each answer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    table_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        n_answered++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction");
          n_errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_if.read_value !== exp_rsp.read_value) begin
            $error("read_value: expected %h, got %h", exp_rsp.read_value, rsp_if.read_value);
            n_errors++;
          end
          if (rsp_if.found !== exp_rsp.found) begin
            $error("found: expected %0d, got %0d", exp_rsp.found, rsp_if.found);
            n_errors++;
          end
          if (rsp_if.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_if.status);
            n_errors++;
          end
          if (rsp_if.entries !== exp_rsp.entries) begin
            $error("entries: expected %0d, got %0d", exp_rsp.entries, rsp_if.entries);
            n_errors++;
          end
          if (exp_rsp.status == lpht_pkg::StatFull) n_full++;
          else if (exp_rsp.status == lpht_pkg::StatNotFound) n_misses++;
          else if (exp_rsp.found) n_hits++;
        end
      end
      // One long hold-off mid-run while the sender keeps offering
      if (!hold_done && n_answered == 150) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= (n_answered >= 300 && n_answered < 420) || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_if.ready) || (rsp_if.valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLim) begin
      $display("Watchdog expired with %0d results outstanding", expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [63:0] k_a;
    logic [63:0] k_b;
    logic [63:0] k_c;
    for (int i = 0; i < Depth; i++) begin
      shadow_mark[i]  = lpht_pkg::MarkEmpty;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    shadow_live  = '0;
    shadow_slots = 9'd256;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, empty key, junk past the terminator, every command
    k_a = 64'h5a5a_0000_0000_0000;
    k_b = 64'hffff_ffff_ffff_ffff;
    k_c = 64'h0000_0000_0080_7f01;
    queue_cmd(lpht_pkg::CmdSet, k_a, 64'h0);
    queue_cmd(lpht_pkg::CmdGet, 64'h1234_5678_9abc_de00, 64'h0);
    queue_cmd(lpht_pkg::CmdExists, 64'h0, 64'hffff_ffff_ffff_ffff);
    queue_cmd(lpht_pkg::CmdSet, k_b, 64'hffff_ffff_ffff_ffff);
    queue_cmd(lpht_pkg::CmdGet, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdSet, k_c, 64'hdead_beef_0123_4567);
    queue_cmd(lpht_pkg::CmdGet, 64'hffee_ddcc_0080_7f01, 64'h0);
    queue_cmd(lpht_pkg::CmdSet, 64'h1111_2222_0080_7f01, 64'h0000_0000_0000_0001);
    queue_cmd(lpht_pkg::CmdGet, k_c, 64'h0);
    queue_cmd(lpht_pkg::CmdExists, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdRemove, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdGet, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdRemove, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdExists, k_b, 64'h0);
    queue_cmd(lpht_pkg::CmdSet, 64'h8081_8283_8485_8687, 64'h8000_0000_0000_0000);
    queue_cmd(lpht_pkg::CmdGet, 64'h8081_8283_8485_8687, 64'h0);
    queue_cmd(lpht_pkg::CmdRemove, 64'h0, 64'h0);
    queue_cmd(lpht_pkg::CmdGet, 64'h0, 64'h0);
    wait_drained();

    // Single slot: fill, full, tombstone reuse
    write_slots(32'd1);
    queue_cmd(lpht_pkg::CmdSet, 64'h41, 64'h7);
    queue_cmd(lpht_pkg::CmdSet, 64'h42, 64'h8);
    queue_cmd(lpht_pkg::CmdRemove, 64'h41, 64'h0);
    queue_cmd(lpht_pkg::CmdSet, 64'h42, 64'h9);
    queue_cmd(lpht_pkg::CmdGet, 64'h42, 64'h0);
    queue_cmd(lpht_pkg::CmdGet, 64'h41, 64'h0);
    queue_random(60);
    wait_drained();

    // Small tables: frequent full and wrap-around
    write_slots(32'd3);
    queue_random(100);
    wait_drained();
    write_slots(32'd0);
    queue_random(60);
    wait_drained();
    write_slots(32'd17);
    queue_random(140);
    wait_drained();

    // Full size, above range, then a two-slot table
    write_slots(32'd256);
    queue_random(220);
    wait_drained();
    write_slots(32'h1ff);
    queue_random(120);
    wait_drained();
    write_slots(32'd2);
    queue_random(80);
    wait_drained();

    repeat (50) @(posedge clk_i);
    $display("Covered %0d commands over %0d table sizes: %0d hits, %0d misses, %0d full",
             n_accepted, n_cfg, n_hits, n_misses, n_full);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
